// ===== sv/vtu_pkg.sv =====
package vtu_pkg;

  localparam int FracBitsDef = 16;
  localparam int WordBitsDef = 32;

  typedef enum logic [2:0] {
    ACT_LOAD      = 3'd0,
    ACT_POINT     = 3'd1,
    ACT_DIR       = 3'd2,
    ACT_PROJ      = 3'd3,
    ACT_INV_XFORM = 3'd4,
    ACT_SCALE     = 3'd5,
    ACT_INV_ORTHO = 3'd6,
    ACT_NOP       = 3'd7
  } action_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic       start;
    logic       mul_en;
    logic       acc_en;
    logic       fin_en;
    logic       commit_en;
    logic       emit;
    logic       phase;
    logic [1:0] term;
    logic [3:0] row;
    action_e    act;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== sv/vtu_if.sv =====
interface vtu_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [3:0]        elem_index;
  logic signed [31:0] elem_value;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] vec_w;

  modport source (
    output valid, action, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
    input  ready
  );
  modport sink (
    input  valid, action, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
    output ready
  );
endinterface

interface vtu_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic              saturated;

  modport source (
    output valid, out_x, out_y, out_z, out_w, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, saturated,
    output ready
  );
endinterface

// ===== sv/vtu_ctrl.sv =====
module vtu_ctrl import vtu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  action_e action_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_ACC    = 6'b000100,
    ST_FIN    = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  action_e    act_q, act_d;
  logic       phase_q, phase_d;
  logic [1:0] term_q, term_d;
  logic [3:0] row_q, row_d;
  logic [1:0] last_term;
  logic [3:0] last_row;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    case (act_q)
      ACT_POINT, ACT_PROJ: last_term = 2'd3;
      ACT_DIR:             last_term = 2'd2;
      ACT_INV_XFORM:       last_term = phase_q ? 2'd2 : 2'd1;
      ACT_INV_ORTHO:       last_term = 2'd2;
      default:             last_term = 2'd0;
    endcase
    case (act_q)
      ACT_PROJ:                                  last_row = 4'd3;
      ACT_POINT, ACT_DIR, ACT_INV_XFORM,
      ACT_INV_ORTHO:                             last_row = 4'd2;
      ACT_SCALE:                                 last_row = 4'd15;
      default:                                   last_row = 4'd0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    phase_d = phase_q;
    term_d  = term_q;
    row_d   = row_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d   = action_i;
          phase_d = 1'b0;
          term_d  = '0;
          row_d   = '0;
          case (action_i)
            ACT_LOAD: state_d = ST_COMMIT;
            ACT_NOP:  state_d = ST_EMIT;
            default:  state_d = ST_MUL;
          endcase
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (term_q == last_term) begin
          state_d = ST_FIN;
        end else begin
          term_d  = term_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_FIN: begin
        term_d = '0;
        if (row_q == last_row) begin
          if (act_q == ACT_INV_XFORM && !phase_q) begin
            // The difference vector is done; now rotate it by the transpose.
            phase_d = 1'b1;
            row_d   = '0;
            state_d = ST_MUL;
          end else if (act_q == ACT_INV_ORTHO) begin
            state_d = ST_COMMIT;
          end else begin
            state_d = ST_EMIT;
          end
        end else begin
          row_d   = row_q + 4'd1;
          state_d = ST_MUL;
        end
      end
      ST_COMMIT: state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      act_q   <= ACT_NOP;
      phase_q <= 1'b0;
      term_q  <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      phase_q <= phase_d;
      term_q  <= term_d;
      row_q   <= row_d;
    end
  end

  assign cmd_o.start     = accept;
  assign cmd_o.mul_en    = (state_q == ST_MUL);
  assign cmd_o.acc_en    = (state_q == ST_ACC);
  assign cmd_o.fin_en    = (state_q == ST_FIN);
  assign cmd_o.commit_en = (state_q == ST_COMMIT);
  assign cmd_o.emit      = (state_q == ST_EMIT) && status_i.out_free;
  assign cmd_o.phase     = phase_q;
  assign cmd_o.term      = term_q;
  assign cmd_o.row       = row_q;
  assign cmd_o.act       = act_q;

endmodule

// ===== sv/vtu_dpath.sv =====
module vtu_dpath import vtu_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef,
  parameter int WORD_BITS = WordBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [3:0]         elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] vec_w_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic signed [31:0] out_w_o,
  output logic               saturated_o
);

  localparam int OutBits = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int OpW     = ((WORD_BITS > 32) ? WORD_BITS : 32) + 1;
  localparam int ProdW   = 2 * OpW;
  localparam int AccW    = ProdW + 2;

  localparam logic signed [AccW-1:0] WMax =
    {{(AccW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [AccW-1:0] WMin = ~WMax;
  localparam logic signed [AccW-1:0] OMax =
    {{(AccW-OutBits+1){1'b0}}, {(OutBits-1){1'b1}}};
  localparam logic signed [AccW-1:0] OMin = ~OMax;
  localparam logic signed [AccW-1:0] OneX = AccW'(1) << FRAC_BITS;
  localparam logic                   OneSat = (OneX > WMax);
  localparam logic signed [WORD_BITS-1:0] OneW =
    OneSat ? WMax[WORD_BITS-1:0] : OneX[WORD_BITS-1:0];
  localparam logic signed [OpW-1:0] UnitOp = OpW'(1) << FRAC_BITS;

  logic signed [WORD_BITS-1:0] m_q [16];
  logic signed [31:0]          vec_q [4];
  logic [3:0]                  idx_q;
  logic signed [31:0]          val_q;
  logic signed [WORD_BITS-1:0] d_q [3];
  logic signed [WORD_BITS-1:0] tcap_q [3];
  logic signed [WORD_BITS-1:0] tnew_q [3];
  logic signed [ProdW-1:0]     prod_q;
  logic signed [AccW-1:0]      acc_q;
  logic signed [31:0]          res_q [4];
  logic                        sat_q;
  logic                        ov_q;
  logic signed [31:0]          oreg_q [4];
  logic                        osat_q;

  function automatic logic signed [WORD_BITS-1:0] clip_w(input logic signed [AccW-1:0] x);
    logic signed [WORD_BITS-1:0] r;
    if (x > WMax) begin
      r = WMax[WORD_BITS-1:0];
    end else if (x < WMin) begin
      r = WMin[WORD_BITS-1:0];
    end else begin
      r = x[WORD_BITS-1:0];
    end
    return r;
  endfunction

  // Operand selection: one matrix read address per cycle.
  logic [3:0]           m_addr;
  logic [1:0]           v_addr;
  logic                 a_unit;
  logic [2:0]           b_sel;
  logic signed [OpW-1:0] a_op, b_op;

  localparam logic [2:0] BVec = 3'd0, BUnit = 3'd1, BNegW = 3'd2, BDiff = 3'd3,
                         BNegT = 3'd4;

  always_comb begin
    m_addr = '0;
    v_addr = '0;
    a_unit = 1'b0;
    b_sel  = BVec;
    case (cmd_i.act)
      ACT_POINT, ACT_DIR, ACT_PROJ: begin
        v_addr = cmd_i.term;
        if (cmd_i.term == 2'd3) begin
          m_addr = {2'b11, cmd_i.row[1:0]};
          b_sel  = BUnit;
        end else begin
          m_addr = {cmd_i.term, cmd_i.row[1:0]};
        end
      end
      ACT_INV_XFORM: begin
        if (!cmd_i.phase) begin
          m_addr = {2'b11, cmd_i.row[1:0]};
          v_addr = cmd_i.row[1:0];
          if (cmd_i.term == 2'd0) begin
            a_unit = 1'b1;
          end else begin
            b_sel = BNegW;
          end
        end else begin
          m_addr = {cmd_i.row[1:0], cmd_i.term};
          b_sel  = BDiff;
        end
      end
      ACT_SCALE: begin
        m_addr = cmd_i.row;
        v_addr = cmd_i.row[3:2];
      end
      ACT_INV_ORTHO: begin
        m_addr = {cmd_i.row[1:0], cmd_i.term};
        b_sel  = BNegT;
      end
      default: ;
    endcase
  end

  always_comb begin
    a_op = a_unit ? UnitOp : OpW'(m_q[m_addr]);
    case (b_sel)
      BUnit:   b_op = UnitOp;
      BNegW:   b_op = -OpW'(vec_q[3]);
      BDiff:   b_op = OpW'(d_q[cmd_i.term]);
      BNegT:   b_op = -OpW'(tcap_q[cmd_i.term]);
      default: b_op = OpW'(vec_q[v_addr]);
    endcase
  end

  // Floor by FRAC_BITS, then clip to the word range or the output range.
  logic signed [AccW-1:0]      sh;
  logic                        w_sat, o_sat;
  logic signed [WORD_BITS-1:0] w_val;
  logic signed [OutBits-1:0]   o_val;
  logic signed [AccW-1:0]      ld_x;
  logic                        ld_sat;

  always_comb begin
    sh    = acc_q >>> FRAC_BITS;
    w_sat = (sh > WMax) || (sh < WMin);
    w_val = clip_w(sh);
    o_sat = (sh > OMax) || (sh < OMin);
    if (sh > OMax) begin
      o_val = OMax[OutBits-1:0];
    end else if (sh < OMin) begin
      o_val = OMin[OutBits-1:0];
    end else begin
      o_val = sh[OutBits-1:0];
    end
    ld_x   = AccW'(val_q);
    ld_sat = (ld_x > WMax) || (ld_x < WMin);
  end

  logic fin_word;
  assign fin_word = (cmd_i.act == ACT_SCALE) || (cmd_i.act == ACT_INV_ORTHO) ||
                    (cmd_i.act == ACT_INV_XFORM && !cmd_i.phase);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        m_q[i] <= (i % 5 == 0) ? OneW : '0;
      end
    end else if (cmd_i.fin_en && cmd_i.act == ACT_SCALE) begin
      m_q[cmd_i.row] <= w_val;
    end else if (cmd_i.commit_en && cmd_i.act == ACT_LOAD) begin
      m_q[idx_q] <= clip_w(ld_x);
    end else if (cmd_i.commit_en && cmd_i.act == ACT_INV_ORTHO) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          m_q[c*4+r] <= m_q[r*4+c];
        end
        m_q[12+c] <= tnew_q[c];
        m_q[c*4+3] <= '0;
      end
      m_q[15] <= OneW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      idx_q    <= elem_index_i;
      val_q    <= elem_value_i;
      vec_q[0] <= vec_x_i;
      vec_q[1] <= vec_y_i;
      vec_q[2] <= vec_z_i;
      vec_q[3] <= vec_w_i;
      for (int i = 0; i < 3; i++) begin
        tcap_q[i] <= m_q[12+i];
      end
      for (int i = 0; i < 4; i++) begin
        res_q[i] <= '0;
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= a_op * b_op;
    end
    if (cmd_i.acc_en) begin
      acc_q <= (cmd_i.term == 2'd0 ? '0 : acc_q) + AccW'(prod_q);
    end
    if (cmd_i.fin_en) begin
      case (cmd_i.act)
        ACT_INV_XFORM: begin
          if (cmd_i.phase) begin
            res_q[cmd_i.row[1:0]] <= 32'(o_val);
          end else begin
            d_q[cmd_i.row[1:0]] <= w_val;
          end
        end
        ACT_INV_ORTHO: tnew_q[cmd_i.row[1:0]] <= w_val;
        ACT_SCALE: ;
        default: res_q[cmd_i.row[1:0]] <= 32'(o_val);
      endcase
    end
    if (cmd_i.emit) begin
      for (int i = 0; i < 4; i++) begin
        oreg_q[i] <= res_q[i];
      end
      osat_q <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        sat_q <= 1'b0;
      end else if (cmd_i.fin_en) begin
        sat_q <= sat_q | (fin_word ? w_sat : o_sat);
      end else if (cmd_i.commit_en && cmd_i.act == ACT_LOAD) begin
        sat_q <= sat_q | ld_sat;
      end else if (cmd_i.commit_en && cmd_i.act == ACT_INV_ORTHO) begin
        sat_q <= sat_q | OneSat;
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_x_o     = oreg_q[0];
  assign out_y_o     = oreg_q[1];
  assign out_z_o     = oreg_q[2];
  assign out_w_o     = oreg_q[3];
  assign saturated_o = osat_q;

endmodule

// ===== sv/vertex_transform_unit.sv =====
// Vertex transform unit: holds a 4x4 column-major Q16.16 matrix (identity after
// reset) and applies one action per request taken on in_i.
// in_i carries the action and its operands; out_o returns one result per
// request: x, y, z, w and a saturation flag. Matrix-only actions return zeros.
// One request is worked on at a time. A single multiplier with a product
// register and an accumulator does each multiply-accumulate in a MUL and an
// ACC state, and each result word then takes a FIN state to round and clip.
// A load passes COMMIT then EMIT, the unused code only EMIT, and the other
// actions loop MUL, ACC and FIN before EMIT; invert ortho also passes COMMIT.
// in_i.ready is high again in the cycle after the result is registered.
// The result register holds one finished result; if the receiver stalls, the
// next request is still taken and processed, and it waits at the end only
// until that register is free.
// An asynchronous low reset clears the control and sets the matrix to identity.
module vertex_transform_unit import vtu_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef,
  parameter int WORD_BITS = WordBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vtu_in_if.sink    in_i,
  vtu_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;

  vtu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .action_i   (action_e'(in_i.action)),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vtu_dpath #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .elem_index_i (in_i.elem_index),
    .elem_value_i (in_i.elem_value),
    .vec_x_i      (in_i.vec_x),
    .vec_y_i      (in_i.vec_y),
    .vec_z_i      (in_i.vec_z),
    .vec_w_i      (in_i.vec_w),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_x_o      (out_o.out_x),
    .out_y_o      (out_o.out_y),
    .out_z_o      (out_o.out_z),
    .out_w_o      (out_o.out_w),
    .saturated_o  (out_o.saturated)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request taken while a previous one is in progress");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.mul_en, cmd.acc_en, cmd.fin_en, cmd.commit_en, cmd.emit}))
    else $error("more than one datapath command at once");

  a_emit_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !in_i.ready)
    else $error("result emitted while idle");
`endif

endmodule

// ===== test/tb_vertex_transform_unit.sv =====
`timescale 1ns / 100ps

module tb_vertex_transform_unit;
  import vtu_pkg::*;

  localparam int FracBits = FracBitsDef;
  localparam int WordBits = WordBitsDef;
  localparam int OutBits = (WordBits < 32) ? WordBits : 32;
  localparam int NumRandom = 600;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               sat;
  } vtx_result_t;

  // Predicts the block from its own copy of the matrix and holds pending results.
  class vtx_scoreboard;
    logic signed [63:0] mtx[16];
    vtx_result_t pending[$];
    int mismatches;

    function void reset_matrix();
      logic dummy;
      for (int i = 0; i < 16; i++) mtx[i] = (i % 5 == 0) ? unit_word(dummy) : 64'sd0;
    endfunction

    function logic signed [63:0] unit_word(inout logic sat);
      return clip(64'sd1 <<< FracBits, WordBits, sat);
    endfunction

    function logic signed [63:0] clip(logic signed [127:0] v, int bits, inout logic sat);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = (128'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        sat = 1'b1;
        return hi[63:0];
      end
      if (v < lo) begin
        sat = 1'b1;
        return lo[63:0];
      end
      return v[63:0];
    endfunction

    // Floor by the fraction bits, then saturate.
    function logic signed [63:0] round_clip(logic signed [127:0] acc, int bits,
                                             inout logic sat);
      return clip(acc >>> FracBits, bits, sat);
    endfunction

    function void note_request(action_e act, logic [3:0] idx, logic signed [31:0] val,
                               logic signed [31:0] vx, logic signed [31:0] vy,
                               logic signed [31:0] vz, logic signed [31:0] vw);
      logic signed [63:0] v[4];
      logic signed [63:0] res[4];
      logic signed [63:0] d[3];
      logic signed [63:0] old[16];
      logic signed [127:0] acc;
      logic signed [127:0] one;
      logic sat;
      vtx_result_t e;
      int rows;
      v[0] = vx; v[1] = vy; v[2] = vz; v[3] = vw;
      for (int i = 0; i < 4; i++) res[i] = 0;
      sat = 1'b0;
      one = 128'sd1 <<< FracBits;
      case (act)
        ACT_LOAD: mtx[idx] = clip(128'(val), WordBits, sat);
        ACT_POINT, ACT_DIR, ACT_PROJ: begin
          rows = (act == ACT_PROJ) ? 4 : 3;
          for (int r = 0; r < rows; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) acc += 128'(mtx[c*4+r]) * 128'(v[c]);
            if (act != ACT_DIR) acc += 128'(mtx[12+r]) * one;
            res[r] = round_clip(acc, OutBits, sat);
          end
        end
        ACT_INV_XFORM: begin
          for (int c = 0; c < 3; c++) begin
            acc = 128'(v[c]) * one - 128'(mtx[12+c]) * 128'(v[3]);
            d[c] = round_clip(acc, WordBits, sat);
          end
          for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) acc += 128'(mtx[r*4+c]) * 128'(d[c]);
            res[r] = round_clip(acc, OutBits, sat);
          end
        end
        ACT_SCALE: begin
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
              mtx[c*4+r] = round_clip(128'(mtx[c*4+r]) * 128'(v[c]), WordBits, sat);
        end
        ACT_INV_ORTHO: begin
          old = mtx;
          for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++) mtx[c*4+r] = old[r*4+c];
          for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) acc -= 128'(old[r*4+c]) * 128'(old[12+c]);
            mtx[12+r] = round_clip(acc, WordBits, sat);
          end
          mtx[3] = 0; mtx[7] = 0; mtx[11] = 0;
          mtx[15] = unit_word(sat);
        end
        default: ;
      endcase
      e.x = res[0][31:0]; e.y = res[1][31:0]; e.z = res[2][31:0]; e.w = res[3][31:0];
      e.sat = sat;
      pending.push_back(e);
    endfunction

    function void check_result(vtx_result_t got);
      vtx_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d", got.x);
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.w !== e.w ||
          got.sat !== e.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d %0d %0d %0d sat %0d, got %0d %0d %0d %0d sat %0d",
                   e.x, e.y, e.z, e.w, e.sat, got.x, got.y, got.z, got.w, got.sat);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  vtu_in_if in_if ();
  vtu_out_if out_if ();
  vtx_scoreboard board;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  always #2 clk_i = ~clk_i;

  vertex_transform_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  initial begin
    in_if.valid = 1'b0;
    in_if.action = '0;
    in_if.elem_index = '0;
    in_if.elem_value = '0;
    in_if.vec_x = '0;
    in_if.vec_y = '0;
    in_if.vec_z = '0;
    in_if.vec_w = '0;
    out_if.ready = 1'b0;
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
      3: return 32'sh1_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(action_e act, logic [3:0] idx, logic signed [31:0] val,
                              logic signed [31:0] vx, logic signed [31:0] vy,
                              logic signed [31:0] vz, logic signed [31:0] vw);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.elem_index <= idx;
    in_if.elem_value <= val;
    in_if.vec_x <= vx;
    in_if.vec_y <= vy;
    in_if.vec_z <= vz;
    in_if.vec_w <= vw;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_request(act, idx, val, vx, vy, vz, vw);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    action_e act;
    logic signed [31:0] s[4];
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) act = ACT_LOAD;
    else if (pick < 45) act = ACT_POINT;
    else if (pick < 55) act = ACT_DIR;
    else if (pick < 67) act = ACT_PROJ;
    else if (pick < 79) act = ACT_INV_XFORM;
    else if (pick < 87) act = ACT_SCALE;
    else if (pick < 95) act = ACT_INV_ORTHO;
    else act = ACT_NOP;
    for (int i = 0; i < 4; i++) s[i] = pick_value();
    // Scale mostly by factors in [-1.0, +1.0] so the matrix does not grow and clip.
    if (act == ACT_SCALE && $urandom_range(0, 3) != 0)
      for (int i = 0; i < 4; i++)
        s[i] = $signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
    send_request(act, 4'($urandom), pick_value(), s[0], s[1], s[2], s[3]);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) out_if.ready <= 1'b0;
      else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    vtx_result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.x = out_if.out_x; got.y = out_if.out_y; got.z = out_if.out_z;
      got.w = out_if.out_w; got.sat = out_if.saturated;
      board.check_result(got);
    end
  end

  initial begin
    @(posedge hold_off);
    repeat (400) @(negedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_vertex_transform_unit NOT OK");
      $finish;
    end
  end

  initial begin
    board = new();
    board.reset_matrix();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Directed: identity behavior, every action, field extremes.
    send_request(ACT_POINT, 0, 0, 32'sh1_0000, 32'sh8000_0000, 32'sh7fff_ffff, 0);
    send_request(ACT_PROJ, 0, 0, 32'sh2_0000, -32'sh3_0000, 32'sh4_0000, 0);
    send_request(ACT_LOAD, 4'd12, 32'sh7fff_ffff, 0, 0, 0, 0);
    send_request(ACT_LOAD, 4'd13, 32'sh8000_0000, 0, 0, 0, 0);
    send_request(ACT_LOAD, 4'd14, 32'sh0003_8000, 0, 0, 0, 0);
    send_request(ACT_POINT, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh1, 0);
    send_request(ACT_DIR, 0, 0, -32'sh1, 32'sh1, 32'sh7fff_ffff, 0);
    send_request(ACT_PROJ, 0, 0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 0);
    send_request(ACT_INV_XFORM, 0, 0, 32'sh1_0000, 32'sh2_0000, 0, 32'sh1_0000);
    send_request(ACT_INV_XFORM, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0, 32'sh8000_0000);
    send_request(ACT_LOAD, 4'd1, 32'shffff_0000, 0, 0, 0, 0);
    send_request(ACT_LOAD, 4'd4, 32'sh0001_0000, 0, 0, 0, 0);
    send_request(ACT_LOAD, 4'd0, 32'sh0, 0, 0, 0, 0);
    send_request(ACT_LOAD, 4'd5, 32'sh0, 0, 0, 0, 0);
    send_request(ACT_INV_ORTHO, 0, 0, 0, 0, 0, 0);
    send_request(ACT_POINT, 0, 0, 32'sh5_0000, -32'sh2_0000, 32'sh1234, 0);
    send_request(ACT_SCALE, 0, 0, 32'sh2_0000, 32'sh8000, -32'sh1_0000, 32'sh7fff_ffff);
    send_request(ACT_NOP, 4'hf, 32'sh7fff_ffff, 32'sh1, 32'sh1, 32'sh1, 32'sh1);
    send_request(ACT_PROJ, 0, 0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 0);
    send_request(ACT_INV_ORTHO, 0, 0, 0, 0, 0, 0);
    send_request(ACT_SCALE, 0, 0, 32'sh8000_0000, 0, 32'sh7fff_ffff, 32'sh8000_0000);
    send_request(ACT_INV_ORTHO, 0, 0, 0, 0, 0, 0);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 150) hold_off = 1'b1;
      if (n == NumRandom - 100) no_idle = 1'b1;
      send_random();
    end
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (board.mismatches == 0) $display("tb_vertex_transform_unit OK");
    else $display("tb_vertex_transform_unit NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/vtu_pkg.sv
sv/vtu_if.sv
sv/vtu_ctrl.sv
sv/vtu_dpath.sv
sv/vertex_transform_unit.sv
test/tb_vertex_transform_unit.sv
